/* src/csfw_pkg.sv */
`timescale 1ns / 1ps

package csfw_pkg;

	// Wait queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

	// Count width and reset limit
	localparam int          CNT_W     = 16;
	localparam logic [15:0] SEM_LIMIT = 16'hFFFF;

	// Configuration register indexes
	localparam logic REG_MAX_COUNT  = 1'b0;
	localparam logic REG_INIT_COUNT = 1'b1;

	// Commands
	localparam logic [1:0] CMD_PEND  = 2'd0;
	localparam logic [1:0] CMD_POST  = 2'd1;
	localparam logic [1:0] CMD_SET   = 2'd2;
	localparam logic [1:0] CMD_FLUSH = 2'd3;

	// Result status codes
	localparam logic [3:0] STS_ACQUIRED    = 4'd0;
	localparam logic [3:0] STS_UNAVAILABLE = 4'd1;
	localparam logic [3:0] STS_QUEUED      = 4'd2;
	localparam logic [3:0] STS_QUEUE_FULL  = 4'd3;
	localparam logic [3:0] STS_POSTED      = 4'd4;
	localparam logic [3:0] STS_POST_SAT    = 4'd5;
	localparam logic [3:0] STS_WOKEN       = 4'd6;
	localparam logic [3:0] STS_RELEASED    = 4'd7;
	localparam logic [3:0] STS_SET_DONE    = 4'd8;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_OP    = 4'b0010,
		ST_WAKE  = 4'b0100,
		ST_FLUSH = 4'b1000
	} seq_state_t;

endpackage

/* src/counting_semaphore_fifo_waiters.sv */
`timescale 1ns / 1ps

// Counting semaphore with a first-come wait queue of task ids. One command is
// taken at a time; s_tready is low while a command is at work. A pend returns
// one result. A post or a set returns a woken result per woken waiter followed
// by its own result. A flush returns a released result per queued waiter (no
// result on an empty queue). The sequencer drives one shared increment/decrement
// adder and one magnitude comparator; the wait queue pops one entry per cycle
// while the output register is free. Each result is held in an output register,
// so a stalled master side holds the sequencer.
// Writing init_count loads the count unclamped; write config only while idle.
module counting_semaphore_fifo_waiters
	import csfw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// Command channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // task_id[5:0], has_timeout[6], new_count[22:7], zero[23]
	input  logic [1:0]  s_tuser,  // command[1:0]
	// Result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // count_value[15:0], woken_task[21:16], wake_flag[22], zero[23]
	output logic [3:0]  m_tuser,  // status[3:0]
	output logic        m_tlast   // last
);

	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	seq_state_t state_q;

	// Latched command
	logic [1:0]       cmd_q;
	logic [5:0]       task_q;
	logic             tmo_q;
	logic [CNT_W-1:0] newc_q;
	logic [3:0]       final_sts_q;

	// Semaphore state
	logic [CNT_W-1:0] max_q;
	logic [CNT_W-1:0] count_q;
	logic [5:0]       wait_queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [OCC_W-1:0] occ_q;

	// Output register
	logic             out_valid_q;
	logic [3:0]       out_sts_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [5:0]       out_task_q;
	logic             out_flag_q;
	logic             out_last_q;

	// Shared arithmetic unit
	logic             alu_dec;
	logic [CNT_W-1:0] alu_sum;
	logic [CNT_W-1:0] cmp_a;
	logic [CNT_W-1:0] cmp_b;
	logic             cmp_lt;

	logic             in_acc;
	logic             cfg_acc;
	logic             out_free;
	logic             out_load;
	logic             count_nz;
	logic             occ_nz;
	logic [5:0]       head_task;
	logic [PTR_W-1:0] head_next;
	logic [PTR_W-1:0] tail_next;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || m_tready;
	assign count_nz  = (count_q != '0);
	assign occ_nz    = (occ_q != '0);
	assign head_task = wait_queue_q[head_q];
	assign head_next = (head_q == PTR_LAST) ? '0 : PTR_W'(head_q + 1'b1);
	assign tail_next = (tail_q == PTR_LAST) ? '0 : PTR_W'(tail_q + 1'b1);

	// Load a new result whenever a result state finds the output register free
	assign out_load = out_free && (((state_q == ST_OP) && (cmd_q == CMD_PEND)) ||
			(state_q == ST_WAKE) || (state_q == ST_FLUSH));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_flag_q, out_task_q, out_cnt_q};
	assign m_tuser  = out_sts_q;
	assign m_tlast  = out_last_q;

	// Select operands of the shared adder and comparator
	always_comb begin
		alu_dec = !((state_q == ST_OP) && (cmd_q == CMD_POST));
		alu_sum = count_q + (alu_dec ? {CNT_W{1'b1}} : CNT_W'(1));
		if (cmd_q == CMD_SET) begin
			cmp_a = max_q;
			cmp_b = newc_q;
		end else begin
			cmp_a = count_q;
			cmp_b = max_q;
		end
		cmp_lt = (cmp_a < cmp_b);
	end

	// Store waiters
	always_ff @(posedge clk) begin
		if ((state_q == ST_OP) && (cmd_q == CMD_PEND) && out_free && !count_nz && tmo_q &&
				(occ_q != OCC_FULL)) begin
			wait_queue_q[tail_q] <= task_q;
		end
	end

	// Capture the command
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= s_tuser;
			task_q <= s_tdata[5:0];
			tmo_q  <= s_tdata[6];
			newc_q <= s_tdata[22:7];
		end
	end

	// Sequence the command and keep the semaphore state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_q       <= SEM_LIMIT;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			final_sts_q <= STS_POSTED;
			out_valid_q <= 1'b0;
		end else begin
			// Hold a result until the master side takes it
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			if (cfg_acc) begin
				case (cfg_index)
					REG_MAX_COUNT:  max_q   <= cfg_data;
					REG_INIT_COUNT: count_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_OP;
					end
				end
				ST_OP: begin
					case (cmd_q)
						CMD_PEND: begin
							if (out_free) begin
								out_cnt_q   <= count_q;
								out_task_q  <= '0;
								out_flag_q  <= 1'b0;
								out_last_q  <= 1'b1;
								state_q     <= ST_IDLE;
								if (count_nz) begin
									out_sts_q <= STS_ACQUIRED;
									count_q   <= alu_sum;
								end else if (!tmo_q) begin
									out_sts_q <= STS_UNAVAILABLE;
								end else if (occ_q == OCC_FULL) begin
									out_sts_q <= STS_QUEUE_FULL;
								end else begin
									out_sts_q <= STS_QUEUED;
									tail_q    <= tail_next;
									occ_q     <= OCC_W'(occ_q + 1'b1);
								end
							end
						end
						CMD_POST: begin
							if (cmp_lt) begin
								count_q     <= alu_sum;
								final_sts_q <= STS_POSTED;
							end else begin
								final_sts_q <= STS_POST_SAT;
							end
							state_q <= ST_WAKE;
						end
						CMD_SET: begin
							count_q     <= cmp_lt ? max_q : newc_q;
							final_sts_q <= STS_SET_DONE;
							state_q     <= ST_WAKE;
						end
						default: begin
							state_q <= occ_nz ? ST_FLUSH : ST_IDLE;
						end
					endcase
				end
				ST_WAKE: begin
					if (out_free) begin
						if (count_nz && occ_nz) begin
							// Wake the oldest waiter with one unit
							out_sts_q  <= STS_WOKEN;
							out_cnt_q  <= alu_sum;
							out_task_q <= head_task;
							out_flag_q <= 1'b1;
							out_last_q <= 1'b0;
							count_q    <= alu_sum;
							head_q     <= head_next;
							occ_q      <= OCC_W'(occ_q - 1'b1);
						end else begin
							out_sts_q  <= final_sts_q;
							out_cnt_q  <= count_q;
							out_task_q <= '0;
							out_flag_q <= 1'b0;
							out_last_q <= 1'b1;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						// Release the oldest waiter without a unit
						out_sts_q   <= STS_RELEASED;
						out_cnt_q   <= count_q;
						out_task_q  <= head_task;
						out_flag_q  <= 1'b0;
						out_last_q  <= (occ_q == OCC_W'(1));
						head_q      <= head_next;
						occ_q       <= OCC_W'(occ_q - 1'b1);
						if (occ_q == OCC_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Occupancy never exceeds the queue depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("wait queue occupancy above depth");

	// Empty or full queue has head and tail together
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == OCC_FULL) |-> (head_q == tail_q))
		else $error("queue pointers disagree with occupancy");

	// A woken result carries the wake flag and is never the last result
	a_woken_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STS_WOKEN) |-> (m_tdata[22] && !m_tlast))
		else $error("woken result with bad flag or last");

	// Command acceptance closes the input until the command is done
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("second command accepted while busy");

endmodule
